// File: design/tgce_pkg.sv
// Shared types, constants and the sine table for the turtle graphics command engine.
package tgce_pkg;

    localparam int CANVAS_SIZE_DEF = 512;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        OP_RESET     = 3'd0,
        OP_PEN_DOWN  = 3'd1,
        OP_PEN_UP    = 3'd2,
        OP_TURN      = 3'd3,
        OP_MOVE      = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        K_NOP,
        K_RESET,
        K_PEN_DOWN,
        K_PEN_UP,
        K_TURN,
        K_MOVE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] amount;
        logic [8:0]         turn_mod;   // amount reduced into 0..359
    } t_q_entry;

    localparam logic [9:0]  DEG_FULL    = 10'd360;
    localparam logic [9:0]  DEG_QUARTER = 10'd90;
    localparam logic [8:0]  DEG_HALF    = 9'd180;
    localparam logic [8:0]  DEG_3QTR    = 9'd270;

    // amount + MOD_OFFSET is non-negative and keeps the same residue mod 360
    localparam logic [16:0] MOD_OFFSET  = 17'd33120;
    localparam logic [30:0] RECIP_360   = 31'd11651;   // ceil(2^22 / 360)
    localparam int          RECIP_SHIFT = 22;

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // Q2.14 sine of a whole-degree angle in 0..359, folded onto the first quadrant
    function automatic logic signed [15:0] sine_q14(input logic [8:0] deg);
        logic [8:0]  idx;
        logic        neg;
        logic [14:0] mag;
        if (deg <= DEG_QUARTER[8:0]) begin
            idx = deg;
            neg = 1'b0;
        end else if (deg <= DEG_HALF) begin
            idx = DEG_HALF - deg;
            neg = 1'b0;
        end else if (deg <= DEG_3QTR) begin
            idx = deg - DEG_HALF;
            neg = 1'b1;
        end else begin
            idx = DEG_FULL[8:0] - deg;
            neg = 1'b1;
        end
        mag = QUARTER_SINE[idx[6:0]];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// File: design/tgce_cmd_if.sv
// Command channel: valid/ready with opcode and amount.
interface tgce_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [15:0] amount;

    modport source (output valid, opcode, amount, input ready);
    modport sink   (input valid, opcode, amount, output ready);
endinterface

// File: design/tgce_res_if.sv
// Result channel: valid/ready with old and new coordinates, draw and pen flags.
interface tgce_res_if;
    logic               valid;
    logic               ready;
    logic               draw;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic               pen_is_down;

    modport source (output valid, draw, from_x, from_y, to_x, to_y, pen_is_down,
                    input ready);
    modport sink   (input valid, draw, from_x, from_y, to_x, to_y, pen_is_down,
                    output ready);
endinterface

// File: design/tgce_front.sv
// Front end: accepts commands, classifies them and reduces turn angles mod 360.
module tgce_front
    import tgce_pkg::*;
(
    tgce_cmd_if.sink   i_cmd,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_q_entry   o_push_entry
);

    logic [16:0] w_u;
    logic [30:0] w_prod;
    logic [8:0]  w_quot;
    logic [16:0] w_rem;

    assign o_push_valid = i_cmd.valid;
    assign i_cmd.ready  = i_push_ready;

    // floor(u / 360) by reciprocal; exact over the whole offset range
    assign w_u    = {i_cmd.amount[15], i_cmd.amount} + MOD_OFFSET;
    assign w_prod = {14'd0, w_u} * RECIP_360;
    assign w_quot = w_prod[30:RECIP_SHIFT];
    assign w_rem  = w_u - {8'd0, w_quot} * {7'd0, DEG_FULL};

    always_comb begin
        case (i_cmd.opcode)
            OP_RESET:    o_push_entry.kind = K_RESET;
            OP_PEN_DOWN: o_push_entry.kind = K_PEN_DOWN;
            OP_PEN_UP:   o_push_entry.kind = K_PEN_UP;
            OP_TURN:     o_push_entry.kind = K_TURN;
            OP_MOVE:     o_push_entry.kind = K_MOVE;
            default:     o_push_entry.kind = K_NOP;
        endcase
        o_push_entry.amount   = i_cmd.amount;
        o_push_entry.turn_mod = w_rem[8:0];
    end

endmodule

// File: design/tgce_queue.sv
// Short FIFO of classified commands between front end and back end.
module tgce_queue
    import tgce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push_valid,
    output logic     o_push_ready,
    input  t_q_entry i_push_entry,
    output logic     o_pop_valid,
    input  logic     i_pop_ready,
    output t_q_entry o_pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_q_entry      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          w_push, w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// File: design/tgce_back.sv
// Back end: turtle state, move arithmetic with saturation, and the result register.
module tgce_back
    import tgce_pkg::*;
#(
    parameter int CANVAS_SIZE = CANVAS_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_q_entry   i_pop_entry,
    tgce_res_if.source o_res
);

    localparam logic signed [31:0] HOME_POS = 32'(CANVAS_SIZE / 2) << 16;

    function automatic logic [8:0] cos_index(input logic [8:0] deg);
        logic [9:0] t;
        t = {1'b0, deg} + DEG_QUARTER;
        if (t >= DEG_FULL) begin
            t = t - DEG_FULL;
        end
        return t[8:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] s;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            s = v[31:0];
        end else begin
            s = v[34] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return s;
    endfunction

    // integer part, truncated toward zero
    function automatic logic signed [15:0] int_part(input logic signed [31:0] q);
        logic signed [15:0] hi;
        hi = q[31:16];
        if (q[31] && (q[15:0] != '0)) begin
            hi = hi + 16'sd1;
        end
        return hi;
    endfunction

    logic signed [31:0] r_pos_x, n_pos_x;
    logic signed [31:0] r_pos_y, n_pos_y;
    logic [8:0]         r_heading, n_heading;
    logic               r_pen, n_pen;
    logic signed [15:0] r_sin, r_cos;

    logic               r_out_valid;
    logic               r_draw, n_draw;
    logic               r_out_pen;
    logic signed [31:0] r_from_x, r_from_y, r_to_x, r_to_y;

    logic               w_fire;
    logic signed [31:0] w_prod_x, w_prod_y;
    logic signed [34:0] w_sum_x, w_sum_y;
    logic [9:0]         w_hsum;
    logic [8:0]         w_turned;

    assign w_fire      = i_pop_valid && (!r_out_valid || o_res.ready);
    assign o_pop_ready = w_fire;

    assign w_prod_x = r_sin * i_pop_entry.amount;
    assign w_prod_y = r_cos * i_pop_entry.amount;
    assign w_sum_x  = 35'(r_pos_x) + (35'(w_prod_x) <<< 2);
    assign w_sum_y  = 35'(r_pos_y) - (35'(w_prod_y) <<< 2);

    assign w_hsum   = {1'b0, r_heading} + {1'b0, i_pop_entry.turn_mod};
    assign w_turned = (w_hsum >= DEG_FULL) ? 9'(w_hsum - DEG_FULL) : w_hsum[8:0];

    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_heading = r_heading;
        n_pen     = r_pen;
        n_draw    = 1'b0;
        case (i_pop_entry.kind)
            K_RESET: begin
                n_pos_x   = HOME_POS;
                n_pos_y   = HOME_POS;
                n_heading = '0;
                n_pen     = 1'b1;
            end
            K_PEN_DOWN: n_pen = 1'b1;
            K_PEN_UP:   n_pen = 1'b0;
            K_TURN:     n_heading = w_turned;
            K_MOVE: begin
                n_pos_x = sat32(w_sum_x);
                n_pos_y = sat32(w_sum_y);
                n_draw  = r_pen;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= HOME_POS;
            r_pos_y     <= HOME_POS;
            r_heading   <= '0;
            r_pen       <= 1'b1;
            r_sin       <= '0;
            r_cos       <= Q14_ONE;
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
            r_pen       <= n_pen;
            // trig of the new heading is ready for the next move
            r_sin       <= sine_q14(n_heading);
            r_cos       <= sine_q14(cos_index(n_heading));
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_draw    <= n_draw;
            r_out_pen <= n_pen;
            r_from_x  <= r_pos_x;
            r_from_y  <= r_pos_y;
            r_to_x    <= n_pos_x;
            r_to_y    <= n_pos_y;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.draw        = r_draw;
    assign o_res.pen_is_down = r_out_pen;
    assign o_res.from_x      = int_part(r_from_x);
    assign o_res.from_y      = int_part(r_from_y);
    assign o_res.to_x        = int_part(r_to_x);
    assign o_res.to_y        = int_part(r_to_y);

endmodule

// File: design/turtle_graphics_command_engine.sv
// Top level of the turtle graphics command engine.
// A command accepted into the queue is executed from it once the result register is free
// or being taken, and its result is then held in the result register until taken.
// Throughput: one command per cycle while the result channel is ready; the back end
// updates heading and position unpipelined, with the heading's sine and cosine registered.
// Reset (synchronous, active low): queue empty, no result pending, turtle at the
// canvas center, heading 0, pen down.
module turtle_graphics_command_engine
    import tgce_pkg::*;
#(
    parameter int CANVAS_SIZE = CANVAS_SIZE_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgce_cmd_if.sink   i_cmd,
    tgce_res_if.source o_res
);

    logic     w_push_valid, w_push_ready;
    t_q_entry w_push_entry;
    logic     w_pop_valid, w_pop_ready;
    t_q_entry w_pop_entry;

    tgce_front u_front (
        .i_cmd        (i_cmd),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_entry (w_push_entry)
    );

    tgce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_entry (w_push_entry),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_entry  (w_pop_entry)
    );

    tgce_back #(
        .CANVAS_SIZE (CANVAS_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_entry (w_pop_entry),
        .o_res       (o_res)
    );

    // an empty queue always has room for a command
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pop_valid |-> i_cmd.ready)
        else $error("queue empty but command channel not ready");

    // a new result only follows a command taken from the queue
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && w_pop_ready) || !(o_res.valid && !$past(o_res.valid)) ||
        $past(w_pop_valid && w_pop_ready))
        else $error("result appeared without a dequeued command");

    // only a move can draw
    a_draw_move_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && w_pop_ready && w_pop_entry.kind != K_MOVE) |=> !o_res.draw)
        else $error("draw flag set for a non-move command");

    // the queue never pops what it does not hold
    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_ready |-> w_pop_valid)
        else $error("back end dequeued from an empty queue");

endmodule
